/* hw/rtl/pws_pkg.sv */
// shared types and constants for the proximity window switch
`timescale 1ns / 1ps

package pws_pkg;

  localparam int unsigned WindowDef = 8;

  localparam int unsigned DistW  = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegMinDistance  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxDistance  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegProbeDelayMs = 2'd2;

  localparam logic [DistW-1:0] MinDistanceRst  = 16'h0000;
  localparam logic [DistW-1:0] MaxDistanceRst  = 16'hffff;
  localparam logic [TimeW-1:0] ProbeDelayRst   = 32'h0000_0000;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic [TimeW-1:0] now_ms;
  } in_t;

  typedef struct packed {
    logic trigger;
    logic accepted;
  } out_t;

endpackage

/* hw/rtl/pws_cfg.sv */
// configuration registers and the band limits derived from them
`timescale 1ns / 1ps

module pws_cfg #(
  parameter int unsigned Window = pws_pkg::WindowDef,
  parameter int unsigned SumW   = pws_pkg::DistW + $clog2(Window)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pws_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pws_pkg::CfgW-1:0]      cfg_wdata_i,
  output logic [SumW-1:0]               lo_o,
  output logic [SumW-1:0]               hi_o,
  output logic [SumW-1:0]               mid_o,
  output logic [SumW+3:0]               cap9_o,
  output logic [pws_pkg::TimeW-1:0]     probe_delay_o
);

  logic [pws_pkg::DistW-1:0] min_q, max_q;
  logic [pws_pkg::TimeW-1:0] delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= pws_pkg::MinDistanceRst;
      max_q   <= pws_pkg::MaxDistanceRst;
      delay_q <= pws_pkg::ProbeDelayRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pws_pkg::RegMinDistance:  min_q   <= cfg_wdata_i[pws_pkg::DistW-1:0];
        pws_pkg::RegMaxDistance:  max_q   <= cfg_wdata_i[pws_pkg::DistW-1:0];
        pws_pkg::RegProbeDelayMs: delay_q <= cfg_wdata_i[pws_pkg::TimeW-1:0];
        default: ;
      endcase
    end
  end

  // band limits, registered once more so the sample path only compares
  logic [SumW-1:0] lo_d, hi_d, diff, cap, mid_d;
  logic [SumW+3:0] cap9_d;
  logic [SumW-1:0] lo_q, hi_q, mid_q;
  logic [SumW+3:0] cap9_q;

  always_comb begin
    lo_d   = SumW'(min_q) * SumW'(Window);
    hi_d   = SumW'(max_q) * SumW'(Window);
    diff   = hi_d - lo_d;
    cap    = diff >> 1;
    mid_d  = lo_d + cap;
    cap9_d = {1'b0, cap, 3'b000} + {4'b0000, cap};
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    cap9_q <= cap9_d;
  end

  assign lo_o          = lo_q;
  assign hi_o          = hi_q;
  assign mid_o         = mid_q;
  assign cap9_o        = cap9_q;
  assign probe_delay_o = delay_q;

endmodule

/* hw/rtl/pws_core.sv */
// rate limit, sample window, running sum and presence latch
`timescale 1ns / 1ps

module pws_core #(
  parameter int unsigned Window = pws_pkg::WindowDef,
  parameter int unsigned SumW   = pws_pkg::DistW + $clog2(Window)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  pws_pkg::in_t              item_i,
  input  logic [SumW-1:0]           lo_i,
  input  logic [SumW-1:0]           hi_i,
  input  logic [SumW-1:0]           mid_i,
  input  logic [SumW+3:0]           cap9_i,
  input  logic [pws_pkg::TimeW-1:0] probe_delay_i,
  output pws_pkg::out_t             result_o
);

  logic [pws_pkg::DistW-1:0] win_q [Window];
  logic [pws_pkg::DistW-1:0] win_d [Window];
  logic [SumW-1:0]           sum_q, sum_d;
  logic [pws_pkg::TimeW-1:0] last_q;
  logic                      latch_q;

  logic [pws_pkg::TimeW-1:0] elapsed;
  logic                      pass;
  logic                      in_band;
  logic [SumW-1:0]           dev;
  logic [SumW+3:0]           dev10;
  logic                      present;

  always_comb begin
    elapsed = item_i.now_ms - last_q;
    pass    = elapsed >= probe_delay_i;

    sum_d = sum_q - SumW'(win_q[Window-1]) + SumW'(item_i.distance);
    win_d[0] = item_i.distance;
    for (int i = 1; i < Window; i++) begin
      win_d[i] = win_q[i-1];
    end

    in_band = (sum_d >= lo_i) && (sum_d < hi_i);
    dev     = (sum_d >= mid_i) ? (sum_d - mid_i) : (mid_i - sum_d);
    dev10   = {1'b0, dev, 3'b000} + {3'b000, dev, 1'b0};
    present = in_band && !(dev10 > cap9_i);

    result_o.accepted = pass;
    result_o.trigger  = pass && present && !latch_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Window; i++) begin
        win_q[i] <= '0;
      end
      sum_q   <= '0;
      last_q  <= '0;
      latch_q <= 1'b0;
    end else if (step_i && pass) begin
      win_q   <= win_d;
      sum_q   <= sum_d;
      last_q  <= item_i.now_ms;
      latch_q <= present;
    end
  end

endmodule

/* hw/rtl/proximity_window_switch.sv */
// top level of the proximity window switch: beat registers around the core
`timescale 1ns / 1ps

// Takes one distance beat per cycle while results are taken, and returns one
// result beat for each, in order. A beat is held in an input register,
// evaluated combinationally against the window sum and the presence latch,
// and its result lands in an output register. One beat per cycle is
// sustained because the window shift, running sum, rate check and latch all
// update together when the beat is evaluated; a stalled result only holds
// off input once both registers are full. Configuration writes land in
// registers, and the band limits derived from them are registered once more.
module proximity_window_switch #(
  parameter int unsigned Window = pws_pkg::WindowDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  pws_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pws_pkg::out_t               out_data_o,
  input  logic                        cfg_we_i,
  input  logic [pws_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pws_pkg::CfgW-1:0]    cfg_wdata_i
);

  localparam int unsigned SumW = pws_pkg::DistW + $clog2(Window);

  logic [SumW-1:0]           lo, hi, mid;
  logic [SumW+3:0]           cap9;
  logic [pws_pkg::TimeW-1:0] probe_delay;

  pws_cfg #(
    .Window (Window),
    .SumW   (SumW)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .lo_o          (lo),
    .hi_o          (hi),
    .mid_o         (mid),
    .cap9_o        (cap9),
    .probe_delay_o (probe_delay)
  );

  logic          in_vld_q, out_vld_q;
  pws_pkg::in_t  in_q;
  pws_pkg::out_t out_q, result;
  logic          step;

  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  pws_core #(
    .Window (Window),
    .SumW   (SumW)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .item_i        (in_q),
    .lo_i          (lo),
    .hi_i          (hi),
    .mid_i         (mid),
    .cap9_i        (cap9),
    .probe_delay_i (probe_delay),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
